@@ src/asc_pkg.sv @@
`timescale 1ns / 1ps
package asc_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CC  = 2'd1;
  localparam logic [1:0] ST_BAD_ALS = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [6:0] OT_AAC_LC = 7'd2;
  localparam logic [6:0] OT_SBR    = 7'd5;
  localparam logic [6:0] OT_BSAC   = 7'd22;
  localparam logic [6:0] OT_PS     = 7'd29;
  localparam logic [4:0] OT_ESC    = 5'd31;
  localparam logic [6:0] OT_ALS    = 7'd36;

  localparam logic [3:0]  IDX_EXPLICIT = 4'h0f;
  localparam logic [3:0]  CC_LIMIT     = 4'd14;
  localparam logic [10:0] SYNC_SBR_KEY = 11'h2b7;
  localparam logic [10:0] SYNC_PS_KEY  = 11'h548;
  localparam logic [23:0] ALS_PEEK_KEY = 24'h414C53;
  localparam logic [31:0] ALS_KEY      = 32'h414C5300;
  localparam int          ALS_MIN_BITS = 112;

  localparam logic [1:0] FLAG_UNKNOWN = 2'b11;
  localparam logic [1:0] FLAG_OFF     = 2'b00;
  localparam logic [1:0] FLAG_ON      = 2'b01;

  localparam int OUT_W = 112;

  typedef struct packed {
    logic busy;
    logic done;
  } asc_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_RD_ADDR, S_RD_BIT,
    S_TYPE, S_TYPE_D, S_TYPE_E,
    S_RIDX, S_RIDX_D, S_RATE24,
    S_CORE_T, S_CORE_R, S_CC_D, S_PS_PEEK,
    S_SBR, S_SBR_R, S_SBR_T, S_SPEC,
    S_ALS1, S_ALS2, S_ALS3, S_ALS4, S_ALS5, S_ALS6, S_ALS7,
    S_SYNC_CHK, S_SCAN, S_SCAN_P, S_SYNC_T0, S_SYNC_T, S_SYNC_SBR, S_SYNC_R,
    S_SYNC_PS, S_SYNC_PS2, S_SYNC_PS3, S_FINAL, S_EMIT
  } asc_state_t;

  function automatic logic [23:0] rate_of(input logic [3:0] idx);
    logic [23:0] r;
    case (idx)
      4'd0:    r = 24'd96000;
      4'd1:    r = 24'd88200;
      4'd2:    r = 24'd64000;
      4'd3:    r = 24'd48000;
      4'd4:    r = 24'd44100;
      4'd5:    r = 24'd32000;
      4'd6:    r = 24'd24000;
      4'd7:    r = 24'd22050;
      4'd8:    r = 24'd16000;
      4'd9:    r = 24'd12000;
      4'd10:   r = 24'd11025;
      4'd11:   r = 24'd8000;
      4'd12:   r = 24'd7350;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] chans_of(input logic [3:0] cc);
    logic [4:0] c;
    case (cc)
      4'd1:    c = 5'd1;
      4'd2:    c = 5'd2;
      4'd3:    c = 5'd3;
      4'd4:    c = 5'd4;
      4'd5:    c = 5'd5;
      4'd6:    c = 5'd6;
      4'd7:    c = 5'd8;
      4'd11:   c = 5'd7;
      4'd12:   c = 5'd8;
      4'd13:   c = 5'd24;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

endpackage

@@ src/audio_specific_config_parser.sv @@
`timescale 1ns / 1ps
// Bytes of one AudioSpecificConfig stream in one per cycle while in_tready is high, and
// are kept in an on-chip byte store of MAX_BYTES entries; bytes past that are dropped. The
// transaction with tlast set starts the parse, and no further byte is taken until its
// result has been handed to the output register. The parser walks the stored bits one at
// a time through the store's registered read port, with an address state and a bit state
// per bit; with the sync extension scan enabled, each scan position re-reads eleven bits.
// The result leaves as one transaction with the status in tuser.
module audio_specific_config_parser #(
  parameter int MAX_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,    // sync_extension_enable
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,       // byte_value
  input  logic          in_tlast,       // is_last
  output logic          out_tvalid,
  input  logic          out_tready,
  // core_type[6:0], freq_index[10:7], core_rate[41:11], chan_cfg[45:42],
  // channel_count[62:46], sbr_flag[64:63], ps_flag[66:65], ext_type[73:67],
  // ext_freq_index[77:74], ext_rate[101:78], specific_bit_offset[111:102]
  output logic [111:0]  out_tdata,
  output logic [1:0]    out_tuser       // status
);
  import asc_pkg::*;

  localparam int AW = $clog2(MAX_BYTES);
  localparam int CW = $clog2(MAX_BYTES + 1);

  logic          sync_en_r;
  logic          job_push, job_pop, job_full, job_empty;
  logic [CW-1:0] push_count, pop_count;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  asc_stat_t     back_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      sync_en_r <= cfg_wr_data;
    end
  end

  asc_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .job_full  (job_full),
    .job_push  (job_push),
    .job_count (push_count),
    .back_stat (back_stat),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  asc_fifo #(.W(CW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_count),
    .pop       (job_pop),
    .full      (job_full),
    .empty     (job_empty),
    .pop_data  (pop_count)
  );

  asc_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (!job_empty),
    .job_count  (pop_count),
    .job_pop    (job_pop),
    .raddr      (raddr),
    .rdata      (rdata),
    .sync_en    (sync_en_r),
    .stat       (back_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef NO_ASSERTIONS
  a_no_load_while_parsing: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.busy |-> !in_tready)
    else $error("byte accepted while the parser reads the store");

  a_no_job_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("error result carries nonzero fields");

  a_done_frees_front: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.done |=> !back_stat.busy)
    else $error("parser still busy after delivering a result");
`endif

endmodule

@@ src/asc_front.sv @@
`timescale 1ns / 1ps
module asc_front #(
  parameter int MAX_BYTES = 64,
  parameter int AW = $clog2(MAX_BYTES),
  parameter int CW = $clog2(MAX_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                job_full,
  output logic                job_push,
  output logic [CW-1:0]       job_count,
  input  asc_pkg::asc_stat_t  back_stat,
  input  logic [AW-1:0]       raddr,
  output logic [7:0]          rdata
);
  import asc_pkg::*;

  logic [7:0]    mem [MAX_BYTES];
  logic [7:0]    rdata_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          hold_r, hold_nxt;
  logic          accept, room;

  assign in_tready = !hold_r && !job_full;
  assign accept    = in_tvalid && in_tready;
  assign room      = count_r < CW'(MAX_BYTES);
  assign job_push  = accept && in_tlast;
  assign job_count = room ? count_r + CW'(1) : count_r;
  assign rdata     = rdata_r;

  always_comb begin
    count_nxt = count_r;
    hold_nxt  = hold_r;
    if (back_stat.done) begin
      hold_nxt = 1'b0;
    end
    if (accept) begin
      if (in_tlast) begin
        count_nxt = '0;
        hold_nxt  = 1'b1;
      end else if (room) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hold_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count_r[AW-1:0]] <= in_tdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ src/asc_fifo.sv @@
`timescale 1ns / 1ps
module asc_fifo #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         empty,
  output logic [W-1:0] pop_data
);
  import asc_pkg::*;

  logic [W-1:0] slot_r [2];
  logic         wptr_r, rptr_r;
  logic [1:0]   fill_r;

  assign full     = fill_r == 2'd2;
  assign empty    = fill_r == 2'd0;
  assign pop_data = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr_r <= !wptr_r;
      end
      if (pop && !empty) begin
        rptr_r <= !rptr_r;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill_r <= fill_r + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ src/asc_back.sv @@
`timescale 1ns / 1ps
module asc_back #(
  parameter int MAX_BYTES = 64,
  parameter int AW = $clog2(MAX_BYTES),
  parameter int CW = $clog2(MAX_BYTES + 1),
  parameter int PW = CW + 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  input  logic [CW-1:0]              job_count,
  output logic                       job_pop,
  output logic [AW-1:0]              raddr,
  input  logic [7:0]                 rdata,
  input  logic                       sync_en,
  output asc_pkg::asc_stat_t         stat,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [asc_pkg::OUT_W-1:0]  out_tdata,
  output logic [1:0]                 out_tuser
);
  import asc_pkg::*;

  asc_state_t state_r, state_nxt, ret_r, ret_nxt, tret_r, tret_nxt, rret_r, rret_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [PW-1:0] pos_r, pos_nxt, save_r, save_nxt, tot_r, tot_nxt, left;
  logic [6:0]  tval_r, tval_nxt, otype_r, otype_nxt, eot_r, eot_nxt;
  logic [3:0]  ridx_r, ridx_nxt, sidx_r, sidx_nxt, cc_r, cc_nxt, eidx_r, eidx_nxt;
  logic [23:0] rval_r, rval_nxt, erate_r, erate_nxt;
  logic [30:0] rate_r, rate_nxt;
  logic [16:0] chans_r, chans_nxt;
  logic [1:0]  sbr_r, sbr_nxt, ps_r, ps_nxt, status_r, status_nxt, ps_v;
  logic [9:0]  spec_r, spec_nxt;
  logic        expl_r, expl_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        bit_in, emit_load, ps_keep;

  assign left      = tot_r - pos_r;
  assign raddr     = pos_r[AW+2:3];
  assign bit_in    = (pos_r < tot_r) && rdata[~pos_r[2:0]];
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign ps_keep   = (acc_r[7:6] != 2'b00) && (acc_r[5:0] == 6'd0);
  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign stat.busy = state_r != S_IDLE;
  assign stat.done = emit_load;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    n_nxt     = n_r;
    tret_nxt  = tret_r;
    rret_nxt  = rret_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          state_nxt = S_TYPE;
          tret_nxt  = S_CORE_T;
        end
      end
      S_RD_ADDR: state_nxt = S_RD_BIT;
      S_RD_BIT: begin
        n_nxt     = n_r - 6'd1;
        state_nxt = (n_r == 6'd1) ? ret_r : S_RD_ADDR;
      end
      S_TYPE: begin
        n_nxt = 6'd5; ret_nxt = S_TYPE_D; state_nxt = S_RD_ADDR;
      end
      S_TYPE_D: begin
        if (acc_r[4:0] == OT_ESC) begin
          n_nxt = 6'd6; ret_nxt = S_TYPE_E; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = tret_r;
        end
      end
      S_TYPE_E: state_nxt = tret_r;
      S_RIDX: begin
        n_nxt = 6'd4; ret_nxt = S_RIDX_D; state_nxt = S_RD_ADDR;
      end
      S_RIDX_D: begin
        if (acc_r[3:0] == IDX_EXPLICIT) begin
          n_nxt = 6'd24; ret_nxt = S_RATE24; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = rret_r;
        end
      end
      S_RATE24: state_nxt = rret_r;
      S_CORE_T: begin
        rret_nxt = S_CORE_R; state_nxt = S_RIDX;
      end
      S_CORE_R: begin
        n_nxt = 6'd4; ret_nxt = S_CC_D; state_nxt = S_RD_ADDR;
      end
      S_CC_D: begin
        if (acc_r[3:0] >= CC_LIMIT) begin
          state_nxt = S_EMIT;
        end else if (otype_r == OT_SBR) begin
          state_nxt = S_SBR;
        end else if (otype_r == OT_PS) begin
          n_nxt = 6'd9; ret_nxt = S_PS_PEEK; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_SPEC;
        end
      end
      S_PS_PEEK: state_nxt = ps_keep ? S_SPEC : S_SBR;
      S_SBR: begin
        rret_nxt = S_SBR_R; state_nxt = S_RIDX;
      end
      S_SBR_R: begin
        tret_nxt = S_SBR_T; state_nxt = S_TYPE;
      end
      S_SBR_T: begin
        if (tval_r == OT_BSAC) begin
          n_nxt = 6'd4; ret_nxt = S_SPEC; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_SPEC;
        end
      end
      S_SPEC: begin
        if (otype_r == OT_ALS) begin
          n_nxt = 6'd5; ret_nxt = S_ALS1; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_SYNC_CHK;
        end
      end
      S_ALS1: begin
        n_nxt = 6'd24; ret_nxt = S_ALS2; state_nxt = S_RD_ADDR;
      end
      S_ALS2: begin
        if (acc_r[23:0] != ALS_PEEK_KEY) begin
          n_nxt = 6'd24; ret_nxt = S_ALS3; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_ALS3;
        end
      end
      S_ALS3: begin
        if (left < PW'(ALS_MIN_BITS)) begin
          state_nxt = S_EMIT;
        end else begin
          n_nxt = 6'd32; ret_nxt = S_ALS4; state_nxt = S_RD_ADDR;
        end
      end
      S_ALS4: begin
        if (acc_r != ALS_KEY) begin
          state_nxt = S_EMIT;
        end else begin
          n_nxt = 6'd32; ret_nxt = S_ALS5; state_nxt = S_RD_ADDR;
        end
      end
      S_ALS5: begin
        if (acc_r == 32'd0 || acc_r[31]) begin
          state_nxt = S_EMIT;
        end else begin
          n_nxt = 6'd32; ret_nxt = S_ALS6; state_nxt = S_RD_ADDR;
        end
      end
      S_ALS6: begin
        n_nxt = 6'd16; ret_nxt = S_ALS7; state_nxt = S_RD_ADDR;
      end
      S_ALS7: state_nxt = S_SYNC_CHK;
      S_SYNC_CHK: state_nxt = (!expl_r && sync_en) ? S_SCAN : S_FINAL;
      S_SCAN: begin
        if (left > PW'(15)) begin
          n_nxt = 6'd11; ret_nxt = S_SCAN_P; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_SCAN_P: begin
        state_nxt = S_RD_ADDR;
        if (acc_r[10:0] == SYNC_SBR_KEY) begin
          n_nxt = 6'd11; ret_nxt = S_SYNC_T0;
        end else begin
          n_nxt = 6'd1; ret_nxt = S_SCAN;
        end
      end
      S_SYNC_T0: begin
        tret_nxt = S_SYNC_T; state_nxt = S_TYPE;
      end
      S_SYNC_T: begin
        if (tval_r == OT_SBR) begin
          n_nxt = 6'd1; ret_nxt = S_SYNC_SBR; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_SYNC_PS;
        end
      end
      S_SYNC_SBR: begin
        if (acc_r[0]) begin
          rret_nxt = S_SYNC_R; state_nxt = S_RIDX;
        end else begin
          state_nxt = S_SYNC_PS;
        end
      end
      S_SYNC_R: state_nxt = S_SYNC_PS;
      S_SYNC_PS: begin
        if (left > PW'(11)) begin
          n_nxt = 6'd11; ret_nxt = S_SYNC_PS2; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_SYNC_PS2: begin
        if (acc_r[10:0] == SYNC_PS_KEY) begin
          n_nxt = 6'd1; ret_nxt = S_SYNC_PS3; state_nxt = S_RD_ADDR;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_SYNC_PS3: state_nxt = S_FINAL;
      S_FINAL:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt    = '0;
    pos_nxt    = pos_r;
    save_nxt   = save_r;
    tot_nxt    = tot_r;
    tval_nxt   = tval_r;
    ridx_nxt   = ridx_r;
    rval_nxt   = rval_r;
    otype_nxt  = otype_r;
    sidx_nxt   = sidx_r;
    rate_nxt   = rate_r;
    cc_nxt     = cc_r;
    chans_nxt  = chans_r;
    sbr_nxt    = sbr_r;
    ps_nxt     = ps_r;
    eot_nxt    = eot_r;
    eidx_nxt   = eidx_r;
    erate_nxt  = erate_r;
    spec_nxt   = spec_r;
    expl_nxt   = expl_r;
    status_nxt = status_r;
    ps_v       = ps_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          pos_nxt    = '0;
          tot_nxt    = {job_count, 3'b000};
          status_nxt = ST_OK;
          sbr_nxt    = FLAG_UNKNOWN;
          ps_nxt     = FLAG_UNKNOWN;
          expl_nxt   = 1'b0;
          eot_nxt    = '0;
          eidx_nxt   = '0;
          erate_nxt  = '0;
        end
      end
      S_RD_ADDR: acc_nxt = acc_r;
      S_RD_BIT: begin
        acc_nxt = {acc_r[30:0], bit_in};
        if (pos_r < tot_r) begin
          pos_nxt = pos_r + PW'(1);
        end
      end
      S_TYPE_D: tval_nxt = {2'b00, acc_r[4:0]};
      S_TYPE_E: tval_nxt = 7'd32 + {1'b0, acc_r[5:0]};
      S_RIDX_D: begin
        ridx_nxt = acc_r[3:0];
        rval_nxt = rate_of(acc_r[3:0]);
      end
      S_RATE24: rval_nxt = acc_r[23:0];
      S_CORE_T: otype_nxt = tval_r;
      S_CORE_R: begin
        sidx_nxt = ridx_r;
        rate_nxt = {7'd0, rval_r};
      end
      S_CC_D: begin
        cc_nxt    = acc_r[3:0];
        chans_nxt = {12'd0, chans_of(acc_r[3:0])};
        save_nxt  = pos_r;
        if (acc_r[3:0] >= CC_LIMIT) begin
          status_nxt = ST_BAD_CC;
        end
      end
      S_PS_PEEK: begin
        pos_nxt = save_r;
        if (!ps_keep) begin
          ps_nxt = FLAG_ON;
        end
      end
      S_SBR: begin
        eot_nxt  = OT_SBR;
        expl_nxt = 1'b1;
        sbr_nxt  = FLAG_ON;
      end
      S_SBR_R: begin
        eidx_nxt  = ridx_r;
        erate_nxt = rval_r;
      end
      S_SBR_T: otype_nxt = tval_r;
      S_SPEC:  spec_nxt = 10'(pos_r);
      S_ALS1:  save_nxt = pos_r;
      S_ALS2:  pos_nxt = save_r;
      S_ALS3: begin
        spec_nxt = 10'(pos_r);
        if (left < PW'(ALS_MIN_BITS)) begin
          status_nxt = ST_BAD_ALS;
        end
      end
      S_ALS4: begin
        if (acc_r != ALS_KEY) begin
          status_nxt = ST_BAD_ALS;
        end
      end
      S_ALS5: begin
        if (acc_r == 32'd0 || acc_r[31]) begin
          status_nxt = ST_BAD_ALS;
        end else begin
          rate_nxt = acc_r[30:0];
        end
      end
      S_ALS7: begin
        cc_nxt    = '0;
        chans_nxt = {1'b0, acc_r[15:0]} + 17'd1;
      end
      S_SCAN:   save_nxt = pos_r;
      S_SCAN_P: pos_nxt = save_r;
      S_SYNC_T: eot_nxt = tval_r;
      S_SYNC_SBR: sbr_nxt = acc_r[0] ? FLAG_ON : FLAG_OFF;
      S_SYNC_R: begin
        eidx_nxt  = ridx_r;
        erate_nxt = rval_r;
        if ({7'd0, rval_r} == rate_r) begin
          sbr_nxt = FLAG_UNKNOWN;
        end
      end
      S_SYNC_PS3: ps_nxt = acc_r[0] ? FLAG_ON : FLAG_OFF;
      S_FINAL: begin
        if (sbr_r == FLAG_OFF) begin
          ps_v = FLAG_OFF;
        end
        if ((ps_v == FLAG_UNKNOWN && otype_r != OT_AAC_LC) || chans_r[16:1] != 16'd0) begin
          ps_v = FLAG_OFF;
        end
        ps_nxt = ps_v;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      if (status_r == ST_OK) begin
        out_data_nxt = {spec_r, erate_r, eidx_r, eot_r, ps_r, sbr_r, chans_r, cc_r,
                        rate_r, sidx_r, otype_r};
      end else begin
        out_data_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      tret_r      <= S_IDLE;
      rret_r      <= S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      tret_r      <= tret_nxt;
      rret_r      <= rret_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    pos_r        <= pos_nxt;
    save_r       <= save_nxt;
    tot_r        <= tot_nxt;
    tval_r       <= tval_nxt;
    ridx_r       <= ridx_nxt;
    rval_r       <= rval_nxt;
    otype_r      <= otype_nxt;
    sidx_r       <= sidx_nxt;
    rate_r       <= rate_nxt;
    cc_r         <= cc_nxt;
    chans_r      <= chans_nxt;
    sbr_r        <= sbr_nxt;
    ps_r         <= ps_nxt;
    eot_r        <= eot_nxt;
    eidx_r       <= eidx_nxt;
    erate_r      <= erate_nxt;
    spec_r       <= spec_nxt;
    expl_r       <= expl_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
